### rtl/tlfrf_pkg.sv
`timescale 1ns / 1ps

package tlfrf_pkg;

    localparam int DEF_SWEEP_POINTS = 17;

    localparam int CODE_W   = 12;
    localparam int ADC_W    = 24;
    localparam int VOLT_W   = 32;
    localparam int ZERO_W   = 16;
    localparam int SCALE_W  = 32;
    localparam int LIM_W    = 24;
    localparam int TRIM_W   = 3;
    localparam int SLOPE_W  = 48;
    localparam int ICPT_W   = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTS_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT     = 2'd3;

    localparam logic [LIM_W-1:0]  RESID_RESET = 24'd1677722;
    localparam logic [TRIM_W-1:0] TRIM_RESET  = 3'd2;
    localparam logic [CODE_W-1:0] FULL_CODE   = 12'hFFF;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_LO,
        RD_HI
    } t_rd_sel;

    typedef struct packed {
        logic    load_in;
        logic    conv_mul;
        logic    conv_wr;
        logic    sum_init;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    sum_mul;
        logic    sum_acc;
        logic    fit_mul;
        logic    fit_sub;
        logic    div_start;
        logic    div_icpt;
        logic    slope_set;
        logic    bmul;
        logic    bsub;
        logic    icpt_set;
        logic    walk_mul;
        logic    lo_cmp;
        logic    hi_cmp;
        logic    out_load;
        logic    out_fail;
    } t_cmd;

    typedef struct packed {
        logic last_pt;
        logic sum_end;
        logic denom_bad;
        logic div_done;
        logic slope_zero;
        logic lo_zero;
        logic hi_top;
        logic walk_ok;
        logic out_full;
    } t_stat;

endpackage

### rtl/tlfrf_pt_if.sv
`timescale 1ns / 1ps

interface tlfrf_pt_if;
    import tlfrf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic [ADC_W-1:0]  adc_mean;

    modport source (output valid, dac_code, adc_mean, input ready);
    modport sink   (input valid, dac_code, adc_mean, output ready);
endinterface

### rtl/tlfrf_fit_if.sv
`timescale 1ns / 1ps

interface tlfrf_fit_if;
    import tlfrf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic [CODE_W-1:0]         min_linear_code;
    logic [CODE_W-1:0]         max_linear_code;
    logic                      fit_ok;

    modport source (output valid, slope, intercept, min_linear_code, max_linear_code, fit_ok,
                    input ready);
    modport sink   (input valid, slope, intercept, min_linear_code, max_linear_code, fit_ok,
                    output ready);
endinterface

### rtl/tlfrf_div.sv
`timescale 1ns / 1ps

module tlfrf_div #(
    parameter int DVW = 74,
    parameter int DSW = 39
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quot
);
    localparam int CNW = $clog2(DVW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DVW-1:0] r_q;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_dvs;

    logic [DSW:0] w_sh;
    logic [DSW:0] w_diff;
    logic         w_ge;

    assign w_sh   = {r_rem, r_q[DVW-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNW'(DVW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DSW-1:0] : w_sh[DSW-1:0];
            r_q   <= {r_q[DVW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !r_done)
        else $error("divider done right after start");
    a_busy_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("divider busy and done together");
endmodule

### rtl/tlfrf_ctrl.sv
`timescale 1ns / 1ps

module tlfrf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output tlfrf_pkg::t_cmd  o_cmd,
    input  tlfrf_pkg::t_stat i_stat
);
    import tlfrf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CMUL, S_CWR,
        S_SINIT, S_SRD, S_SMUL, S_SACC,
        S_FMUL, S_FSUB,
        S_DIV1, S_DW1, S_SLOPE, S_BMUL, S_BSUB, S_DIV2, S_DW2, S_ICPT,
        S_LOCHK, S_LORD, S_LOMUL, S_LOCMP,
        S_HICHK, S_HIRD, S_HIMUL, S_HICMP,
        S_OUT, S_OUTF
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.load_in = i_valid;
                if (i_valid) n_state = S_CMUL;
            end
            S_CMUL: begin
                w_cmd.conv_mul = 1'b1;
                n_state = S_CWR;
            end
            S_CWR: begin
                w_cmd.conv_wr = 1'b1;
                n_state = i_stat.last_pt ? S_SINIT : S_IDLE;
            end
            S_SINIT: begin
                w_cmd.sum_init = 1'b1;
                n_state = S_SRD;
            end
            S_SRD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_IDX;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                w_cmd.sum_mul = 1'b1;
                n_state = S_SACC;
            end
            S_SACC: begin
                w_cmd.sum_acc = 1'b1;
                n_state = i_stat.sum_end ? S_FMUL : S_SRD;
            end
            S_FMUL: begin
                w_cmd.fit_mul = 1'b1;
                n_state = S_FSUB;
            end
            S_FSUB: begin
                w_cmd.fit_sub = 1'b1;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                if (i_stat.denom_bad) begin
                    n_state = S_OUTF;
                end else begin
                    w_cmd.div_start = 1'b1;
                    n_state = S_DW1;
                end
            end
            S_DW1: begin
                if (i_stat.div_done) n_state = S_SLOPE;
            end
            S_SLOPE: begin
                w_cmd.slope_set = 1'b1;
                n_state = S_BMUL;
            end
            S_BMUL: begin
                if (i_stat.slope_zero) begin
                    n_state = S_OUTF;
                end else begin
                    w_cmd.bmul = 1'b1;
                    n_state = S_BSUB;
                end
            end
            S_BSUB: begin
                w_cmd.bsub = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_icpt  = 1'b1;
                n_state = S_DW2;
            end
            S_DW2: begin
                if (i_stat.div_done) n_state = S_ICPT;
            end
            S_ICPT: begin
                w_cmd.icpt_set = 1'b1;
                n_state = S_LOCHK;
            end
            S_LOCHK: begin
                n_state = i_stat.lo_zero ? S_HICHK : S_LORD;
            end
            S_LORD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_LO;
                n_state = S_LOMUL;
            end
            S_LOMUL: begin
                w_cmd.walk_mul = 1'b1;
                n_state = S_LOCMP;
            end
            S_LOCMP: begin
                w_cmd.lo_cmp = 1'b1;
                n_state = i_stat.walk_ok ? S_LOCHK : S_HICHK;
            end
            S_HICHK: begin
                n_state = i_stat.hi_top ? S_OUT : S_HIRD;
            end
            S_HIRD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_HI;
                n_state = S_HIMUL;
            end
            S_HIMUL: begin
                w_cmd.walk_mul = 1'b1;
                n_state = S_HICMP;
            end
            S_HICMP: begin
                w_cmd.hi_cmp = 1'b1;
                n_state = i_stat.walk_ok ? S_HICHK : S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    w_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUTF: begin
                if (!i_stat.out_full) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_fail = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = w_cmd;

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CMUL))
        else $error("accepted word did not start conversion");
endmodule

### rtl/tlfrf_dp.sv
`timescale 1ns / 1ps

module tlfrf_dp #(
    parameter int SWEEP_POINTS = tlfrf_pkg::DEF_SWEEP_POINTS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tlfrf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tlfrf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [tlfrf_pkg::CODE_W-1:0]           i_dac_code,
    input  logic [tlfrf_pkg::ADC_W-1:0]            i_adc_mean,
    input  tlfrf_pkg::t_cmd                        i_cmd,
    output tlfrf_pkg::t_stat                       o_stat,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [tlfrf_pkg::SLOPE_W-1:0]   o_slope,
    output logic signed [tlfrf_pkg::ICPT_W-1:0]    o_intercept,
    output logic [tlfrf_pkg::CODE_W-1:0]           o_min_code,
    output logic [tlfrf_pkg::CODE_W-1:0]           o_max_code,
    output logic                                   o_fit_ok
);
    import tlfrf_pkg::*;

    localparam int AW   = $clog2(SWEEP_POINTS);
    localparam int NW   = $clog2(SWEEP_POINTS + 1);
    localparam int TMAX = (SWEEP_POINTS - 1) / 2;
    localparam int LAST = SWEEP_POINTS - 1;

    localparam int PW   = ADC_W + SCALE_W;
    localparam int RW   = PW + 1;
    localparam int RRW  = RW - 12;

    localparam int SXW  = CODE_W + NW;
    localparam int SYW  = VOLT_W + NW;
    localparam int XXW  = 2 * CODE_W;
    localparam int SXXW = XXW + NW;
    localparam int XYW  = CODE_W + VOLT_W + 1;
    localparam int SXYW = XYW + NW;
    localparam int NUMW = CODE_W + VOLT_W + 3 + 2 * NW;
    localparam int DENW = 2 * CODE_W + 3 + 2 * NW;
    localparam int DVW  = NUMW + 17;

    localparam int QAW  = SLOPE_W - 1;
    localparam int PHW  = QAW - 24 + SXW;
    localparam int PLW  = 24 + SXW;
    localparam int TW   = QAW + SXW + 1;
    localparam int TQW  = 57;
    localparam int BNW  = ((SYW + 16 > TQW + 1) ? SYW + 16 : TQW + 1) + 1;
    localparam int AXW  = SLOPE_W + CODE_W + 1;
    localparam int EW   = AXW + 2;

    localparam logic [RRW-1:0] VPOS_MAX  = RRW'(32'h7FFF_FFFF);
    localparam logic [RRW-1:0] VNEG_MAX  = RRW'(32'h8000_0000);
    localparam logic [DVW-1:0] SLOPE_SAT = DVW'(48'h7FFF_FFFF_FFFF);
    localparam logic [DVW-1:0] IPOS_MAX  = DVW'(32'h7FFF_FFFF);
    localparam logic [DVW-1:0] INEG_MAX  = DVW'(32'h8000_0000);
    localparam logic [TW-1:0]  TQ_MAX    = TW'(1) << 56;

    // config
    logic [ZERO_W-1:0]  r_zero;
    logic [SCALE_W-1:0] r_scale;
    logic [LIM_W-1:0]   r_limit;
    logic [TRIM_W-1:0]  r_trim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero  <= '0;
            r_scale <= '0;
            r_limit <= RESID_RESET;
            r_trim  <= TRIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ZERO_CODE:      r_zero  <= i_cfg_data[ZERO_W-1:0];
                REG_VOLTS_SCALE:    r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_RESIDUAL_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                REG_TRIM_COUNT:     r_trim  <= i_cfg_data[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    // point conversion
    logic [CODE_W-1:0]        r_code;
    logic                     r_neg;
    logic [ADC_W-1:0]         r_mag;
    logic [PW-1:0]            r_prod;
    logic [ADC_W-1:0]         w_zc;
    logic [RW-1:0]            w_rsum;
    logic [RRW-1:0]           w_r;
    logic signed [VOLT_W-1:0] w_volt;

    assign w_zc   = {r_zero, 8'h00};
    assign w_rsum = {1'b0, r_prod} + RW'(2048);
    assign w_r    = w_rsum[RW-1:12];

    always_comb begin
        if (r_neg) begin
            w_volt = (w_r > VNEG_MAX) ? VOLT_W'(32'h8000_0000) : VOLT_W'(-w_r);
        end else begin
            w_volt = (w_r > VPOS_MAX) ? VOLT_W'(32'h7FFF_FFFF) : VOLT_W'(w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_code <= i_dac_code;
            r_neg  <= i_adc_mean > w_zc;
            r_mag  <= (i_adc_mean > w_zc) ? i_adc_mean - w_zc : w_zc - i_adc_mean;
        end
        if (i_cmd.conv_mul) r_prod <= r_mag * r_scale;
    end

    // point store
    logic [CODE_W-1:0]        m_code [SWEEP_POINTS];
    logic signed [VOLT_W-1:0] m_volt [SWEEP_POINTS];
    logic [AW-1:0]            r_cnt;
    logic [CODE_W-1:0]        r_rd_code;
    logic signed [VOLT_W-1:0] r_rd_volt;
    logic [AW-1:0]            w_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.conv_wr) begin
            r_cnt <= (r_cnt == AW'(LAST)) ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.conv_wr) begin
            m_code[r_cnt] <= r_code;
            m_volt[r_cnt] <= w_volt;
        end
    end

    logic [AW-1:0] r_t;
    logic [NW-1:0] r_n;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_lo;
    logic [AW-1:0] r_hi;
    logic [AW-1:0] w_trim;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LO:   w_addr = r_lo - 1'b1;
            RD_HI:   w_addr = r_hi + 1'b1;
            default: w_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_code <= m_code[w_addr];
            r_rd_volt <= m_volt[w_addr];
        end
    end

    assign w_trim = (int'(r_trim) > TMAX) ? AW'(TMAX) : AW'(r_trim);

    // sums
    logic [XXW-1:0]            r_xx;
    logic signed [XYW-1:0]     r_xy;
    logic [CODE_W-1:0]         r_x;
    logic signed [VOLT_W-1:0]  r_y;
    logic [SXW-1:0]            r_sx;
    logic signed [SYW-1:0]     r_sy;
    logic [SXXW-1:0]           r_sxx;
    logic signed [SXYW-1:0]    r_sxy;
    logic [CODE_W-1:0]         r_lo_code;
    logic [CODE_W-1:0]         r_hi_code;
    logic signed [AXW-1:0]     r_ax;
    logic signed [SLOPE_W-1:0] r_slope;
    logic                      w_walk_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t  <= '0;
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_cmd.sum_init) begin
            r_t  <= w_trim;
            r_lo <= w_trim;
            r_hi <= AW'(LAST) - w_trim;
        end else begin
            if (i_cmd.lo_cmp && w_walk_ok) r_lo <= r_lo - 1'b1;
            if (i_cmd.hi_cmp && w_walk_ok) r_hi <= r_hi + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_idx <= w_trim;
            r_n   <= NW'(SWEEP_POINTS) - (NW'(w_trim) << 1);
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
        end
        if (i_cmd.sum_mul) begin
            r_xx <= r_rd_code * r_rd_code;
            r_xy <= $signed({1'b0, r_rd_code}) * r_rd_volt;
            r_x  <= r_rd_code;
            r_y  <= r_rd_volt;
            if (r_idx == r_t) r_lo_code <= r_rd_code;
            if (r_idx == r_hi) r_hi_code <= r_rd_code;
        end
        if (i_cmd.sum_acc) begin
            r_sx  <= r_sx + SXW'(r_x);
            r_sy  <= r_sy + SYW'(r_y);
            r_sxx <= r_sxx + SXXW'(r_xx);
            r_sxy <= r_sxy + SXYW'(r_xy);
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.walk_mul) begin
            r_ax <= r_slope * $signed({1'b0, r_rd_code});
            r_y  <= r_rd_volt;
            r_x  <= r_rd_code;
        end
        if ((i_cmd.lo_cmp || i_cmd.hi_cmp) && w_walk_ok) begin
            if (i_cmd.lo_cmp) r_lo_code <= r_x;
            if (i_cmd.hi_cmp) r_hi_code <= r_x;
        end
    end

    // normal equations
    logic signed [NUMW-1:0] r_nsxy;
    logic signed [NUMW-1:0] r_sxsy;
    logic [DENW-1:0]        r_nsxx;
    logic [DENW-1:0]        r_sxsx;
    logic signed [NUMW-1:0] r_num;
    logic signed [DENW-1:0] r_den;
    logic [NUMW-1:0]        w_num_mag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fit_mul) begin
            r_nsxy <= $signed({1'b0, r_n}) * r_sxy;
            r_sxsy <= $signed({1'b0, r_sx}) * r_sy;
            r_nsxx <= r_n * r_sxx;
            r_sxsx <= r_sx * r_sx;
        end
        if (i_cmd.fit_sub) begin
            r_num <= r_nsxy - r_sxsy;
            r_den <= $signed(r_nsxx) - $signed(r_sxsx);
        end
    end

    assign w_num_mag = r_num[NUMW-1] ? NUMW'(-r_num) : NUMW'(r_num);

    // shared divider
    logic [DVW-1:0]  w_dvd;
    logic [DENW-1:0] w_dvs;
    logic            w_div_done;
    logic [DVW-1:0]  w_q;
    logic [BNW-1:0]  r_bmag;

    always_comb begin
        if (i_cmd.div_icpt) begin
            w_dvd = DVW'(r_bmag) + (DVW'(r_n) << 15);
            w_dvs = DENW'(r_n) << 16;
        end else begin
            w_dvd = (DVW'(w_num_mag) << 16) + DVW'($unsigned(r_den) >> 1);
            w_dvs = $unsigned(r_den);
        end
    end

    tlfrf_div #(
        .DVW (DVW),
        .DSW (DENW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_q)
    );

    // slope and intercept
    logic [QAW-1:0]             r_qa;
    logic                       r_sneg;
    logic [QAW-1:0]             w_qa;
    logic [PHW-1:0]             r_phi;
    logic [PLW-1:0]             r_plo;
    logic [TW-1:0]              w_tfull;
    logic [TW-1:0]              w_tq;
    logic signed [BNW-1:0]      w_tsig;
    logic signed [BNW-1:0]      w_bn;
    logic                       r_bneg;
    logic signed [ICPT_W-1:0]   r_icpt;
    logic signed [ICPT_W-1:0]   w_icpt;

    assign w_qa    = (w_q > SLOPE_SAT) ? {QAW{1'b1}} : w_q[QAW-1:0];
    assign w_tfull = (TW'(r_phi) << 24) + TW'(r_plo);
    assign w_tq    = (w_tfull > TQ_MAX) ? TQ_MAX : w_tfull;
    assign w_tsig  = $signed(BNW'(w_tq[TQW-1:0]));
    assign w_bn    = (BNW'(r_sy) <<< 16) - (r_sneg ? -w_tsig : w_tsig);

    always_comb begin
        if (r_bneg) begin
            w_icpt = (w_q > INEG_MAX) ? ICPT_W'(32'h8000_0000) : ICPT_W'(-w_q);
        end else begin
            w_icpt = (w_q > IPOS_MAX) ? ICPT_W'(32'h7FFF_FFFF) : ICPT_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slope_set) begin
            r_qa    <= w_qa;
            r_sneg  <= r_num[NUMW-1];
            r_slope <= r_num[NUMW-1] ? -$signed({1'b0, w_qa}) : $signed({1'b0, w_qa});
        end
        if (i_cmd.bmul) begin
            r_phi <= r_qa[QAW-1:24] * r_sx;
            r_plo <= r_qa[23:0] * r_sx;
        end
        if (i_cmd.bsub) begin
            r_bneg <= w_bn[BNW-1];
            r_bmag <= w_bn[BNW-1] ? BNW'(-w_bn) : BNW'(w_bn);
        end
        if (i_cmd.icpt_set) r_icpt <= w_icpt;
    end

    // residual check
    logic signed [EW-1:0] w_e;
    logic [EW-1:0]        w_emag;

    assign w_e       = (EW'(r_y) <<< 16) - EW'(r_ax) - (EW'(r_icpt) <<< 16);
    assign w_emag    = w_e[EW-1] ? EW'(-w_e) : EW'(w_e);
    assign w_walk_ok = w_emag <= (EW'(r_limit) << 16);

    // result register
    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_fail) begin
                o_slope     <= '0;
                o_intercept <= '0;
                o_min_code  <= '0;
                o_max_code  <= '0;
                o_fit_ok    <= 1'b0;
            end else begin
                o_slope     <= r_slope;
                o_intercept <= r_icpt;
                o_min_code  <= (r_lo == '0) ? '0 : r_lo_code;
                o_max_code  <= (r_hi == AW'(LAST)) ? FULL_CODE : r_hi_code;
                o_fit_ok    <= 1'b1;
            end
        end
    end

    assign o_valid = r_o_valid;

    assign o_stat.last_pt    = (r_cnt == AW'(LAST));
    assign o_stat.sum_end    = (r_idx == r_hi);
    assign o_stat.denom_bad  = r_den[DENW-1] || (r_den == '0);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.slope_zero = (r_qa == '0);
    assign o_stat.lo_zero    = (r_lo == '0);
    assign o_stat.hi_top     = (r_hi == AW'(LAST));
    assign o_stat.walk_ok    = w_walk_ok;
    assign o_stat.out_full   = r_o_valid && !i_ready;

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("linear range inverted");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_o_valid && !i_ready))
        else $error("result overwritten before taken");
endmodule

### rtl/trimmed_line_fit_range_finder_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields                                                    Handshake
// i_pt      in   dac_code, adc_mean                                        valid/ready
// o_fit     out  slope, intercept, min_linear_code, max_linear_code, fit_ok valid/ready
// i_cfg     in   i_cfg_idx, i_cfg_data                                     i_cfg_we
//
// A point word is accepted, scale-multiplied, then rounded and stored.
// The last point of a sweep starts the fit: sums over the fitted points, products for the
// normal equations, two passes of the bit-serial divider (slope, then intercept; one shift
// per dividend bit, numerator width + 17), then the range walk checks points below the
// fitted range and then above it.
// Synchronous active-low reset; the point store is not cleared, each sweep fills it.
// i_pt.ready is high only between words; a result waiting in the output register
// does not block new points, only the next result.

module trimmed_line_fit_range_finder_core #(
    parameter int SWEEP_POINTS = tlfrf_pkg::DEF_SWEEP_POINTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tlfrf_pt_if.sink                         i_pt,
    tlfrf_fit_if.source                      o_fit,
    input  logic                             i_cfg_we,
    input  logic [tlfrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tlfrf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tlfrf_pkg::*;

    logic  w_in_ready;
    t_cmd  w_cmd;
    t_stat w_stat;

    tlfrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pt.valid),
        .o_ready (w_in_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    tlfrf_dp #(
        .SWEEP_POINTS (SWEEP_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_dac_code  (i_pt.dac_code),
        .i_adc_mean  (i_pt.adc_mean),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_valid     (o_fit.valid),
        .i_ready     (o_fit.ready),
        .o_slope     (o_fit.slope),
        .o_intercept (o_fit.intercept),
        .o_min_code  (o_fit.min_linear_code),
        .o_max_code  (o_fit.max_linear_code),
        .o_fit_ok    (o_fit.fit_ok)
    );

    assign i_pt.ready = w_in_ready;
endmodule

### test/tb_trimmed_line_fit_range_finder_core.sv
`timescale 1ns / 1ps

module tb_trimmed_line_fit_range_finder_core;
    import tlfrf_pkg::*;

    localparam int NPTS      = DEF_SWEEP_POINTS;
    localparam int N_ITEMS   = 1800;
    localparam int IDLE_LIM  = 5000;
    localparam int TAIL_WAIT = 400;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
        logic [CODE_W-1:0]         min_code;
        logic [CODE_W-1:0]         max_code;
        logic                      ok;
    } t_fit_word;

    class fit_scoreboard;
        logic [ZERO_W-1:0]  zero_code;
        logic [SCALE_W-1:0] volts_scale;
        logic [LIM_W-1:0]   resid_lim;
        logic [TRIM_W-1:0]  trim;
        int                 codes[NPTS];
        int                 volts[NPTS];
        int                 count;
        t_fit_word          pending[$];
        int                 errors;

        function new();
            zero_code   = '0;
            volts_scale = '0;
            resid_lim   = RESID_RESET;
            trim        = TRIM_RESET;
            count       = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ZERO_CODE:      zero_code   = data[ZERO_W-1:0];
                REG_VOLTS_SCALE:    volts_scale = data[SCALE_W-1:0];
                REG_RESIDUAL_LIMIT: resid_lim   = data[LIM_W-1:0];
                REG_TRIM_COUNT:     trim        = data[TRIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int scale_point(logic [ADC_W-1:0] adc);
            longint diff;
            longint unsigned mag, r;
            diff = longint'({1'b0, zero_code}) * 256 - longint'({1'b0, adc});
            mag  = (diff < 0) ? longint'(-diff) : diff;
            r    = (mag * longint'({1'b0, volts_scale}) + 2048) >> 12;
            if (diff < 0) begin
                if (r > 64'h8000_0000) r = 64'h8000_0000;
                return int'(-longint'(r));
            end
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
            return int'(r);
        endfunction

        function bit in_band(int i, longint a, longint b);
            longint e;
            longint unsigned m;
            e = longint'(volts[i]) * 65536 - a * longint'(codes[i]) - b * 65536;
            m = (e < 0) ? longint'(-e) : e;
            return m <= (longint'({1'b0, resid_lim}) << 16);
        endfunction

        function t_fit_word line_fit();
            t_fit_word w;
            int t, n, lo, hi, last;
            longint sx, sy, sxx, sxy, denom, num, a, b, bn, den;
            longint unsigned um, ud, q1, r, qa, ahi, alo, usx, t24, f16, tq, bm, bmag;
            w = '0;
            t = trim;
            if (t > (NPTS - 1) / 2) t = (NPTS - 1) / 2;
            n = NPTS - 2 * t;
            last = NPTS - 1;
            sx = 0; sy = 0; sxx = 0; sxy = 0;
            for (int i = t; i < t + n; i++) begin
                sx  += codes[i];
                sy  += volts[i];
                sxx += longint'(codes[i]) * codes[i];
                sxy += longint'(codes[i]) * volts[i];
            end
            denom = n * sxx - sx * sx;
            num   = n * sxy - sx * sy;
            if (denom <= 0) return w;
            um = (num < 0) ? longint'(-num) : num;
            ud = denom;
            q1 = um / ud;
            r  = um % ud;
            if (q1 >= 64'h8000_0000) begin
                qa = 64'h7FFF_FFFF_FFFF;
            end else begin
                qa = (q1 << 16) + (((r << 16) + ud / 2) / ud);
                if (qa > 64'h7FFF_FFFF_FFFF) qa = 64'h7FFF_FFFF_FFFF;
            end
            if (qa == 0) return w;
            a = (num < 0) ? -longint'(qa) : longint'(qa);
            usx = sx;
            ahi = qa >> 24;
            alo = qa & 64'hFF_FFFF;
            t24 = ahi * usx * 256 + ((alo * usx) >> 16);
            f16 = (alo * usx) & 64'hFFFF;
            if (t24 >= (64'd1 << 40)) begin
                t24 = 64'd1 << 40;
                f16 = 0;
            end
            tq = t24 * 65536 + f16;
            bn = sy * 65536 - ((a < 0) ? -longint'(tq) : longint'(tq));
            den = n * 65536;
            bmag = (bn < 0) ? longint'(-bn) : bn;
            bm = (bmag + den / 2) / den;
            if (bn < 0) begin
                if (bm > 64'h8000_0000) bm = 64'h8000_0000;
                b = -longint'(bm);
            end else begin
                if (bm > 64'h7FFF_FFFF) bm = 64'h7FFF_FFFF;
                b = bm;
            end
            lo = t;
            while (lo > 0 && in_band(lo - 1, a, b)) lo--;
            hi = last - t;
            while (hi < last && in_band(hi + 1, a, b)) hi++;
            w.slope     = a[SLOPE_W-1:0];
            w.intercept = b[ICPT_W-1:0];
            w.min_code  = (lo == 0) ? '0 : codes[lo][CODE_W-1:0];
            w.max_code  = (hi == last) ? FULL_CODE : codes[hi][CODE_W-1:0];
            w.ok        = 1'b1;
            return w;
        endfunction

        function void note_point(logic [CODE_W-1:0] code, logic [ADC_W-1:0] adc);
            codes[count] = code;
            volts[count] = scale_point(adc);
            count++;
            if (count == NPTS) begin
                count = 0;
                pending.push_back(line_fit());
            end
        endfunction

        function void check_fit(t_fit_word got);
            t_fit_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected fit word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.slope !== want.slope) begin
                $display("%0t: slope exp %h got %h", $time, want.slope, got.slope);
                errors++;
            end
            if (got.intercept !== want.intercept) begin
                $display("%0t: intercept exp %h got %h", $time, want.intercept,
                         got.intercept);
                errors++;
            end
            if (got.min_code !== want.min_code) begin
                $display("%0t: min code exp %h got %h", $time, want.min_code, got.min_code);
                errors++;
            end
            if (got.max_code !== want.max_code) begin
                $display("%0t: max code exp %h got %h", $time, want.max_code, got.max_code);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $display("%0t: fit_ok exp %b got %b", $time, want.ok, got.ok);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tlfrf_pt_if  pt_bus ();
    tlfrf_fit_if fit_bus ();

    trimmed_line_fit_range_finder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_bus.sink),
        .o_fit      (fit_bus.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fit_scoreboard sb = new();
    bit quiet;
    int idle_cycles;
    int sent;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && fit_bus.valid && fit_bus.ready)
            sb.check_fit({fit_bus.slope, fit_bus.intercept, fit_bus.min_linear_code,
                          fit_bus.max_linear_code, fit_bus.fit_ok});
    end

    always @(posedge i_clk) begin
        if ((pt_bus.valid && pt_bus.ready) || (fit_bus.valid && fit_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        fit_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                fit_bus.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                fit_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                fit_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_point(logic [CODE_W-1:0] code, logic [ADC_W-1:0] adc);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            pt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        pt_bus.valid    <= 1'b1;
        pt_bus.dac_code <= code;
        pt_bus.adc_mean <= adc;
        do @(posedge i_clk); while (!pt_bus.ready);
        sb.note_point(code, adc);
        sent++;
    endtask

    task automatic reconfigure(bit extreme);
        logic [31:0] v;
        pt_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        v = extreme ? ($urandom_range(0, 1) ? 32'hFFFF : 32'h0) : $urandom_range(0, 65535);
        write_reg(REG_ZERO_CODE, v);
        case ($urandom_range(0, 4))
            0: v = extreme ? 32'hFFFF_FFFF : $urandom;
            1: v = 32'h0;
            default: v = $urandom_range(1 << 12, 1 << 22);
        endcase
        write_reg(REG_VOLTS_SCALE, v);
        case ($urandom_range(0, 3))
            0: v = extreme ? 32'hFF_FFFF : 32'h0;
            1: v = $urandom_range(0, 24'hFF_FFFF);
            default: v = $urandom_range(0, 24'h3F_FFFF);
        endcase
        write_reg(REG_RESIDUAL_LIMIT, v);
        v = extreme ? ($urandom_range(0, 1) ? 32'd7 : 32'd0) : $urandom_range(0, 7);
        write_reg(REG_TRIM_COUNT, v);
        // upper data bits and out-of-range values land in unused bits
        write_reg(REG_TRIM_COUNT, {$urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'h0, v[2:0]});
    endtask

    task automatic run_sweep(int kind);
        int base, step, center, slope_adc, clip_lo, clip_hi, kk, val, code;
        base      = $urandom_range(0, 1500);
        step      = $urandom_range(1, 160);
        center    = $urandom_range(0, 24'hFF_FFFF);
        slope_adc = $urandom_range(0, 40000) - 20000;
        clip_lo   = $urandom_range(0, 4);
        clip_hi   = NPTS - 1 - $urandom_range(0, 4);
        for (int k = 0; k < NPTS; k++) begin
            case (kind)
                0: begin
                    kk   = (k < clip_lo) ? clip_lo : (k > clip_hi) ? clip_hi : k;
                    code = base + k * step;
                    if (code > 4095) code = 4095;
                    val  = center + (kk - NPTS / 2) * slope_adc + $urandom_range(0, 600) - 300;
                    if (val < 0) val = 0;
                    if (val > 24'hFF_FFFF) val = 24'hFF_FFFF;
                    send_point(CODE_W'(code), ADC_W'(val));
                end
                1: send_point(CODE_W'($urandom), ADC_W'($urandom));
                2: send_point(CODE_W'(base), ADC_W'($urandom));
                3: send_point(CODE_W'(base + k * step), ADC_W'(center));
                default: send_point(k[0] ? 12'hFFF : 12'h0, k[1] ? 24'hFF_FFFF : 24'h0);
            endcase
        end
    endtask

    initial begin
        quiet        = 1'b0;
        idle_cycles  = 0;
        sent         = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        pt_bus.valid    <= 1'b0;
        pt_bus.dac_code <= '0;
        pt_bus.adc_mean <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero scale, so the slope rounds to zero
        run_sweep(0);
        reconfigure(1'b1);
        run_sweep(4);
        reconfigure(1'b0);
        run_sweep(2);
        run_sweep(3);
        while (sent < N_ITEMS) begin
            if (sent > N_ITEMS * 9 / 10) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) reconfigure($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       run_sweep(1);
                1:       run_sweep($urandom_range(2, 4));
                default: run_sweep(0);
            endcase
        end
        pt_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### trimmed_line_fit_range_finder_core.f
rtl/tlfrf_pkg.sv
rtl/tlfrf_pt_if.sv
rtl/tlfrf_fit_if.sv
rtl/tlfrf_div.sv
rtl/tlfrf_ctrl.sv
rtl/tlfrf_dp.sv
rtl/trimmed_line_fit_range_finder_core.sv
test/tb_trimmed_line_fit_range_finder_core.sv
